>>> src/sse_pkg.sv
// Shared types, constants and prefix lookup for the SSE event framer.
// Used by sse_front, sse_fifo, sse_back, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps

package sse_pkg;

  // Field kinds carried on in_req_type
  localparam logic [1:0] REQ_EVENT   = 2'd0;
  localparam logic [1:0] REQ_DATA    = 2'd1;
  localparam logic [1:0] REQ_COMMENT = 2'd2;

  // Line break bytes
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Step index width: one request expands to at most 15 bytes
  localparam int unsigned STEP_W = 4;

  // Default depth of the request queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Line prefix selector
  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_EVENT,
    PFX_DATA,
    PFX_COMM
  } pfx_t;

  // Line terminator selector
  typedef enum logic [1:0] {
    TERM_NONE,
    TERM_LF,
    TERM_BLANK
  } term_t;

  // Classified request handed from front to back
  typedef struct packed {
    pfx_t       pfx;
    logic       has_byte;
    logic [7:0] data_byte;
    logic       nl_break;
    term_t      term;
  } cmd_t;

  // Prefix length in bytes
  function automatic logic [STEP_W-1:0] pfx_len(input pfx_t p);
    logic [STEP_W-1:0] n;
    case (p)
      PFX_EVENT: n = STEP_W'(7);
      PFX_DATA:  n = STEP_W'(6);
      PFX_COMM:  n = STEP_W'(2);
      default:   n = '0;
    endcase
    return n;
  endfunction

  // Byte at position i of a prefix
  function automatic logic [7:0] pfx_byte(input pfx_t p, input logic [2:0] i);
    logic [7:0] b;
    b = 8'h20;
    case (p)
      PFX_EVENT: begin
        case (i)
          3'd0:    b = 8'h65;  // e
          3'd1:    b = 8'h76;  // v
          3'd2:    b = 8'h65;  // e
          3'd3:    b = 8'h6E;  // n
          3'd4:    b = 8'h74;  // t
          3'd5:    b = 8'h3A;  // :
          default: b = 8'h20;
        endcase
      end
      PFX_DATA: begin
        case (i)
          3'd0:    b = 8'h64;  // d
          3'd1:    b = 8'h61;  // a
          3'd2:    b = 8'h74;  // t
          3'd3:    b = 8'h61;  // a
          3'd4:    b = 8'h3A;  // :
          default: b = 8'h20;
        endcase
      end
      PFX_COMM: begin
        case (i)
          3'd0:    b = 8'h3A;  // :
          default: b = 8'h20;
        endcase
      end
      default: b = 8'h20;
    endcase
    return b;
  endfunction

endpackage

>>> src/sse_event_framer.sv
// Top level of the SSE event framer: classifier, command queue and byte
// sequencer. Depends on sse_pkg, sse_front, sse_fifo and sse_back.
`timescale 1ns / 1ps

// Byte-serial Server-Sent Events framer. Each input request is one content
// byte tagged as event name, data or comment, with first, last and empty
// marks; the block emits the framed wire bytes ("event: ", "data: ", ": "
// prefixes, line breaks mapped to LF plus a fresh "data: ", LF LF closing
// a data event or comment). The front classifies a request in the cycle it
// is pushed, so a request is taken every cycle while the command queue
// (QUEUE_DEPTH entries) has room. The back sequencer emits one output byte
// per cycle while results are popped, so a request that expands to n bytes
// (1 to 15) holds the sequencer until all n are emitted; sustained input rate
// is one request per cycle for plain content bytes while results are popped.
// With the queue and output register idle, an accepted request is written
// into the command queue and its first byte is then loaded into the output register.
module sse_event_framer #(
  parameter int unsigned QUEUE_DEPTH = sse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_byte,
  input  logic       in_first_byte,
  input  logic       in_last_byte,
  input  logic       in_empty_field,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_frame_end
);
  import sse_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  // Classify incoming requests
  sse_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_byte        (in_byte),
    .in_first_byte  (in_first_byte),
    .in_last_byte   (in_last_byte),
    .in_empty_field (in_empty_field),
    .q_push         (q_push),
    .q_cmd          (push_cmd),
    .q_full         (q_full)
  );

  // Buffer classified commands
  sse_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty)
  );

  // Expand commands into wire bytes
  sse_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_cmd         (head_cmd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last),
    .out_frame_end (out_frame_end)
  );

endmodule

>>> src/sse_front.sv
// Front end: accepts input requests, classifies them into framing commands
// and keeps the CR-seen flag for data fields. Depends on sse_pkg.
`timescale 1ns / 1ps

module sse_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_req_type,
  input  logic [7:0]        in_byte,
  input  logic              in_first_byte,
  input  logic              in_last_byte,
  input  logic              in_empty_field,
  output logic              q_push,
  output sse_pkg::cmd_t     q_cmd,
  input  logic              q_full
);
  import sse_pkg::*;

  logic cr_seen_r;
  logic cr_seen_nxt;
  logic accept;
  logic is_nl;
  logic prev_cr;
  logic cmd_live;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign is_nl   = (in_byte == CH_CR) || (in_byte == CH_LF);
  assign prev_cr = in_first_byte ? 1'b0 : cr_seen_r;

  // Classify the request into prefix, body byte, break and terminator
  always_comb begin
    q_cmd           = '0;
    q_cmd.pfx       = PFX_NONE;
    q_cmd.term      = TERM_NONE;
    q_cmd.data_byte = in_byte;
    cr_seen_nxt     = cr_seen_r;
    case (in_req_type)
      REQ_EVENT: begin
        if (!in_empty_field) begin
          q_cmd.pfx      = in_first_byte ? PFX_EVENT : PFX_NONE;
          q_cmd.has_byte = !is_nl;
          q_cmd.term     = in_last_byte ? TERM_LF : TERM_NONE;
        end
      end
      REQ_DATA: begin
        if (in_empty_field) begin
          q_cmd.pfx   = PFX_DATA;
          q_cmd.term  = TERM_BLANK;
          cr_seen_nxt = 1'b0;
        end else begin
          q_cmd.pfx = in_first_byte ? PFX_DATA : PFX_NONE;
          if (in_byte == CH_CR) begin
            q_cmd.nl_break = 1'b1;
            cr_seen_nxt    = 1'b1;
          end else if (in_byte == CH_LF) begin
            q_cmd.nl_break = !prev_cr;
            cr_seen_nxt    = 1'b0;
          end else begin
            q_cmd.has_byte = 1'b1;
            cr_seen_nxt    = 1'b0;
          end
          if (in_last_byte) begin
            q_cmd.term  = TERM_BLANK;
            cr_seen_nxt = 1'b0;
          end
        end
      end
      REQ_COMMENT: begin
        if (in_empty_field) begin
          q_cmd.pfx  = PFX_COMM;
          q_cmd.term = TERM_BLANK;
        end else begin
          q_cmd.pfx      = in_first_byte ? PFX_COMM : PFX_NONE;
          q_cmd.has_byte = !is_nl;
          q_cmd.term     = in_last_byte ? TERM_BLANK : TERM_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  // Drop requests that expand to no bytes at all
  assign cmd_live = (q_cmd.pfx != PFX_NONE) || q_cmd.has_byte || q_cmd.nl_break ||
                    (q_cmd.term != TERM_NONE);
  assign q_push   = accept && cmd_live;

  // Update CR-seen on every accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cr_seen_r <= 1'b0;
    end else if (accept) begin
      cr_seen_r <= cr_seen_nxt;
    end
  end

endmodule

>>> src/sse_fifo.sv
// Short command queue that decouples the classifier from the byte sequencer.
// Depends on sse_pkg for the command type.
`timescale 1ns / 1ps

module sse_fifo #(
  parameter int unsigned DEPTH = sse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sse_pkg::cmd_t     push_cmd,
  output logic              full,
  input  logic              pop,
  output sse_pkg::cmd_t     head_cmd,
  output logic              empty
);
  import sse_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem[rd_ptr_r];

  // Write the incoming command
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> src/sse_back.sv
// Back end: walks each queued command one output byte per cycle unless the
// output stalls, holding the result in an output register. Depends on sse_pkg.
`timescale 1ns / 1ps

module sse_back (
  input  logic              clk,
  input  logic              rst_n,
  input  sse_pkg::cmd_t     q_cmd,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_byte,
  output logic              out_run_last,
  output logic              out_frame_end
);
  import sse_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              run_last_r;
  logic              frame_end_r;

  logic [STEP_W-1:0] end_pfx;
  logic [STEP_W-1:0] end_body;
  logic [STEP_W-1:0] end_break;
  logic [STEP_W-1:0] total;
  logic [STEP_W-1:0] brk_off;
  logic              last_step;
  logic              advance;
  logic              take;
  logic [7:0]        byte_nxt;
  logic              frame_end_nxt;

  // Section boundaries of the expanded byte run
  always_comb begin
    end_pfx   = pfx_len(q_cmd.pfx);
    end_body  = end_pfx + STEP_W'(q_cmd.has_byte);
    end_break = end_body + (q_cmd.nl_break ? STEP_W'(7) : '0);
    case (q_cmd.term)
      TERM_LF:    total = end_break + STEP_W'(1);
      TERM_BLANK: total = end_break + STEP_W'(2);
      default:    total = end_break;
    endcase
    brk_off   = step_r - end_body;
    last_step = (step_r == total - STEP_W'(1));
  end

  // Select the byte at the current step
  always_comb begin
    frame_end_nxt = 1'b0;
    if (step_r < end_pfx) begin
      byte_nxt = pfx_byte(q_cmd.pfx, step_r[2:0]);
    end else if (step_r < end_body) begin
      byte_nxt = q_cmd.data_byte;
    end else if (step_r < end_break) begin
      byte_nxt = (brk_off == '0) ? CH_LF : pfx_byte(PFX_DATA, 3'(brk_off - STEP_W'(1)));
    end else begin
      byte_nxt      = CH_LF;
      frame_end_nxt = (q_cmd.term == TERM_BLANK) && last_step;
    end
  end

  assign advance   = !out_valid_r || out_pop;
  assign take      = advance && !q_empty;
  assign q_pop     = take && last_step;
  assign out_empty = !out_valid_r;

  // Advance the step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else if (advance) begin
      out_valid_r <= !q_empty;
      if (take) begin
        step_r <= last_step ? '0 : step_r + STEP_W'(1);
      end
    end
  end

  // Load the output byte register
  always_ff @(posedge clk) begin
    if (take) begin
      out_byte_r  <= byte_nxt;
      run_last_r  <= last_step;
      frame_end_r <= frame_end_nxt;
    end
  end

  assign out_byte      = out_byte_r;
  assign out_run_last  = run_last_r;
  assign out_frame_end = frame_end_r;

endmodule

>>> src/sse_checker.sv
// Port-level checks for sse_event_framer, attached by bind.
// Depends on sse_pkg and the top level's port list.
`timescale 1ns / 1ps

module sse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_push,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_byte,
  input logic       out_run_last,
  input logic       out_frame_end
);
  import sse_pkg::*;

  // A waiting result stays until it is popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty)
    else $error("result dropped before pop");

  // A waiting result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> $stable(out_byte) && $stable(out_run_last) &&
      $stable(out_frame_end))
    else $error("stalled result changed");

  // A closing blank line is an LF and ends its request's run
  a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_frame_end |-> (out_byte == CH_LF) && out_run_last)
    else $error("frame end on wrong byte");

  // Reset leaves no result waiting and the input open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("state not cleared by reset");

endmodule

bind sse_event_framer sse_checker u_sse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_push       (in_push),
  .in_full       (in_full),
  .out_empty     (out_empty),
  .out_pop       (out_pop),
  .out_byte      (out_byte),
  .out_run_last  (out_run_last),
  .out_frame_end (out_frame_end)
);

>>> tb/sse_event_framer_tb.sv
// Self-checking testbench for sse_event_framer: queued driver, random stalls
// on both sides and a byte-level model of the SSE framing.
// Depends on sse_pkg and the sse_event_framer RTL.
`timescale 1ns / 1ps

module sse_event_framer_tb;
  import sse_pkg::*;

  // Field kind with no meaning; the block must ignore it
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       empty;
  } field_req_t;

  typedef struct packed {
    logic [7:0] wire_byte;
    logic       run_last;
    logic       frame_end;
  } wire_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic [1:0] in_req_type = REQ_EVENT;
  logic [7:0] in_byte = 8'h00;
  logic in_first_byte = 1'b0;
  logic in_last_byte = 1'b0;
  logic in_empty_field = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [7:0] out_byte;
  logic out_run_last;
  logic out_frame_end;

  field_req_t pending_reqs[$];
  wire_byte_t expected_bytes[$];
  wire_byte_t burst[$];

  // Model state: previous data byte was CR
  logic model_cr_seen = 1'b0;

  int unsigned n_issued = 0;
  int unsigned n_accepted = 0;
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned phase = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;
  logic in_taken = 1'b0;

  sse_event_framer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_byte        (in_byte),
    .in_first_byte  (in_first_byte),
    .in_last_byte   (in_last_byte),
    .in_empty_field (in_empty_field),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_frame_end  (out_frame_end)
  );

  always #5 clk = ~clk;

  // Append one wire byte to the burst of the current request
  task automatic emit_byte(input logic [7:0] b, input logic fend);
    wire_byte_t w;
    w.wire_byte = b;
    w.run_last = 1'b0;
    w.frame_end = fend;
    burst.push_back(w);
  endtask

  task automatic emit_text(input string s);
    for (int i = 0; i < s.len(); i++) emit_byte(s[i], 1'b0);
  endtask

  task automatic emit_blank_line();
    emit_byte(CH_LF, 1'b0);
    emit_byte(CH_LF, 1'b1);
  endtask

  // Expand one accepted request into its wire bytes
  task automatic frame_request(input field_req_t r);
    logic is_nl;
    logic prev_cr;
    wire_byte_t w;
    is_nl = (r.data == CH_CR) || (r.data == CH_LF);
    burst.delete();
    case (r.kind)
      REQ_EVENT: begin
        if (!r.empty) begin
          if (r.first) emit_text("event: ");
          if (!is_nl) emit_byte(r.data, 1'b0);
          if (r.last) emit_byte(CH_LF, 1'b0);
        end
      end
      REQ_DATA: begin
        if (r.empty) begin
          emit_text("data: ");
          emit_blank_line();
          model_cr_seen = 1'b0;
        end else begin
          prev_cr = r.first ? 1'b0 : model_cr_seen;
          if (r.first) emit_text("data: ");
          if (r.data == CH_CR) begin
            emit_byte(CH_LF, 1'b0);
            emit_text("data: ");
            model_cr_seen = 1'b1;
          end else if (r.data == CH_LF) begin
            // swallow the LF of a CRLF pair
            if (!prev_cr) begin
              emit_byte(CH_LF, 1'b0);
              emit_text("data: ");
            end
            model_cr_seen = 1'b0;
          end else begin
            emit_byte(r.data, 1'b0);
            model_cr_seen = 1'b0;
          end
          if (r.last) begin
            emit_blank_line();
            model_cr_seen = 1'b0;
          end
        end
      end
      REQ_COMMENT: begin
        if (r.empty) begin
          emit_text(": ");
          emit_blank_line();
        end else begin
          if (r.first) emit_text(": ");
          if (!is_nl) emit_byte(r.data, 1'b0);
          if (r.last) emit_blank_line();
        end
      end
      default: ;
    endcase
    // mark the final byte of this request
    if (burst.size() > 0) begin
      w = burst.pop_back();
      w.run_last = 1'b1;
      burst.push_back(w);
    end
    while (burst.size() > 0) expected_bytes.push_back(burst.pop_front());
  endtask

  task automatic add_req(input logic [1:0] kind, input logic [7:0] data,
                         input logic first, input logic last, input logic empty);
    field_req_t r;
    r.kind = kind;
    r.data = data;
    r.first = first;
    r.last = last;
    r.empty = empty;
    pending_reqs.push_back(r);
    n_issued++;
  endtask

  // Content byte biased toward line breaks
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(7, 0);
    if (r == 0) return CH_CR;
    if (r == 1) return CH_LF;
    return 8'($urandom_range(255, 0));
  endfunction

  function automatic logic [1:0] pick_kind();
    int unsigned r;
    r = $urandom_range(2, 0);
    if (r == 0) return REQ_EVENT;
    if (r == 1) return REQ_DATA;
    return REQ_COMMENT;
  endfunction

  // Mostly well-formed fields, some broken marks, a little ignored noise
  task automatic add_random_reqs(input int unsigned count);
    int unsigned made;
    int unsigned r;
    int unsigned len;
    logic [1:0] kind;
    made = 0;
    while (made < count) begin
      r = $urandom_range(99, 0);
      kind = pick_kind();
      if (r < 70) begin
        if ($urandom_range(9, 0) == 0) begin
          add_req(kind, 8'($urandom), 1'($urandom), 1'($urandom), 1'b1);
          if (kind != REQ_EVENT) made++;
        end else begin
          len = $urandom_range(8, 1);
          for (int i = 0; i < len; i++)
            add_req(kind, pick_byte(), i == 0, i == len - 1, 1'b0);
          made += len;
        end
      end else if (r < 90) begin
        len = $urandom_range(4, 1);
        for (int i = 0; i < len; i++)
          add_req(pick_kind(), pick_byte(), 1'($urandom), 1'($urandom), 1'b0);
        made += len;
      end else begin
        add_req(REQ_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  // Drive the next request; hold it until it is taken
  always @(negedge clk) begin
    field_req_t r;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || in_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99, 0) >= send_idle) begin
        r = pending_reqs.pop_front();
        in_push <= 1'b1;
        in_req_type <= r.kind;
        in_byte <= r.data;
        in_first_byte <= r.first;
        in_last_byte <= r.last;
        in_empty_field <= r.empty;
      end else begin
        in_push <= 1'b0;
        in_req_type <= 2'($urandom);
        in_byte <= 8'($urandom);
        in_first_byte <= 1'($urandom);
        in_last_byte <= 1'($urandom);
        in_empty_field <= 1'($urandom);
      end
    end
  end

  // Pop results at random; hold off once for a long stretch in the last phase
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_left > 0) begin
      out_pop <= 1'b0;
      hold_left = hold_left - 1;
    end else if (phase == 2 && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99, 0) >= recv_idle);
    end
  end

  // Predict on each accepted request, check each accepted result, watch for hangs
  always @(posedge clk) begin
    wire_byte_t e;
    logic took_in;
    logic took_out;
    took_in = rst_n && in_push && !in_full;
    took_out = rst_n && out_pop && !out_empty;
    in_taken <= took_in;
    if (took_in) begin
      frame_request({in_req_type, in_byte, in_first_byte, in_last_byte, in_empty_field});
      n_accepted++;
    end
    if (took_out) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %h run_last %b frame_end %b",
               out_byte, out_run_last, out_frame_end);
        errors++;
      end else begin
        e = expected_bytes.pop_front();
        if (out_byte !== e.wire_byte) begin
          $error("out_byte: expected %h, got %h", e.wire_byte, out_byte);
          errors++;
        end
        if (out_run_last !== e.run_last) begin
          $error("out_run_last: expected %b, got %b", e.run_last, out_run_last);
          errors++;
        end
        if (out_frame_end !== e.frame_end) begin
          $error("out_frame_end: expected %b, got %b", e.frame_end, out_frame_end);
          errors++;
        end
      end
    end
    if (!rst_n || took_in || took_out) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    send_idle = 32;
    recv_idle = 77;
    phase = 0;

    // Event name with dropped CR/LF and byte extremes
    add_req(REQ_EVENT, 8'h00, 1'b1, 1'b0, 1'b0);
    add_req(REQ_EVENT, CH_CR, 1'b0, 1'b0, 1'b0);
    add_req(REQ_EVENT, CH_LF, 1'b0, 1'b0, 1'b0);
    add_req(REQ_EVENT, 8'hFF, 1'b0, 1'b1, 1'b0);
    add_req(REQ_EVENT, 8'h78, 1'b1, 1'b1, 1'b0);
    // empty event name emits nothing
    add_req(REQ_EVENT, 8'h41, 1'b1, 1'b1, 1'b1);
    // Data with CR, CRLF, lone LF and CR CR
    add_req(REQ_DATA, 8'h68, 1'b1, 1'b0, 1'b0);
    add_req(REQ_DATA, CH_CR, 1'b0, 1'b0, 1'b0);
    add_req(REQ_DATA, CH_LF, 1'b0, 1'b0, 1'b0);
    add_req(REQ_DATA, CH_LF, 1'b0, 1'b0, 1'b0);
    add_req(REQ_DATA, CH_CR, 1'b0, 1'b0, 1'b0);
    add_req(REQ_DATA, CH_CR, 1'b0, 1'b0, 1'b0);
    add_req(REQ_DATA, 8'h7A, 1'b0, 1'b1, 1'b0);
    // Stale CR from an unterminated field must not swallow a fresh LF
    add_req(REQ_DATA, CH_CR, 1'b1, 1'b0, 1'b0);
    add_req(REQ_DATA, CH_LF, 1'b1, 1'b1, 1'b0);
    // Empty data and empty comment
    add_req(REQ_DATA, 8'hFF, 1'b0, 1'b0, 1'b1);
    add_req(REQ_COMMENT, 8'h00, 1'b0, 1'b0, 1'b1);
    // Comment with dropped line breaks
    add_req(REQ_COMMENT, 8'h3A, 1'b1, 1'b0, 1'b0);
    add_req(REQ_COMMENT, CH_CR, 1'b0, 1'b0, 1'b0);
    add_req(REQ_COMMENT, CH_LF, 1'b0, 1'b1, 1'b0);
    // Unused kind, missing marks, and the longest expansion
    add_req(REQ_UNUSED, 8'hFF, 1'b1, 1'b1, 1'b0);
    add_req(REQ_DATA, 8'hFF, 1'b0, 1'b0, 1'b0);
    add_req(REQ_DATA, CH_CR, 1'b1, 1'b1, 1'b0);
    add_random_reqs(60);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Swap stall rates between phases, then run flat out with one long hold-off
    while (pending_reqs.size() > 0) @(posedge clk);
    send_idle = 77;
    recv_idle = 32;
    phase = 1;
    add_random_reqs(85);
    while (pending_reqs.size() > 0) @(posedge clk);
    send_idle = 0;
    recv_idle = 0;
    phase = 2;
    add_random_reqs(85);

    // Drain: everything taken, every expected byte seen, then a short tail
    while (n_accepted < n_issued) @(posedge clk);
    while (expected_bytes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sse_event_framer.f
src/sse_pkg.sv
src/sse_front.sv
src/sse_fifo.sv
src/sse_back.sv
src/sse_event_framer.sv
src/sse_checker.sv
tb/sse_event_framer_tb.sv
